@@ hdl/odpack_pkg.sv @@
// ----------------------------------------------------------------------------
// odpack_pkg
// Shared types, register indexes, mode codes and dither tables for the
// ordered-dither RGBA5551 packer.
// ----------------------------------------------------------------------------
package odpack_pkg;

    localparam int CHAN_W    = 8;
    localparam int POS_W     = 12;
    localparam int WORD_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 2;
    localparam int THR_W     = 4;
    localparam int SUM_W     = CHAN_W + 2;

    localparam int CHAN_MAX    = 255;
    localparam int RED_SHIFT   = 11;
    localparam int GREEN_SHIFT = 6;
    localparam int BLUE_SHIFT  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_APPLY_DITHER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DITHER_MODE  = 1'd1;

    // dither_mode codes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_BAYER = 2'd1;
    localparam logic [1:0] MODE_MAGIC = 2'd2;
    localparam logic [1:0] MODE_BLUE  = 2'd3;   // not supported, acts as none

    typedef logic signed [THR_W-1:0] t_thr;

    typedef struct packed {
        logic       apply_dither;
        logic [1:0] dither_mode;
    } t_cfg;

    // [x & 3][y & 3]
    localparam t_thr BAYER4 [4][4] = '{
        '{-4'sd4,  4'sd2, -4'sd3,  4'sd4},
        '{ 4'sd0, -4'sd2,  4'sd2, -4'sd1},
        '{-4'sd3,  4'sd3, -4'sd4,  4'sd3},
        '{ 4'sd1, -4'sd1,  4'sd1, -4'sd2}
    };

    localparam t_thr MAGIC4 [4][4] = '{
        '{-4'sd4,  4'sd2,  4'sd2, -4'sd1},
        '{ 4'sd3, -4'sd2, -4'sd3,  4'sd1},
        '{-4'sd3,  4'sd0,  4'sd4, -4'sd2},
        '{ 4'sd3, -4'sd1, -4'sd4,  4'sd1}
    };

endpackage

@@ hdl/odpack_ifs.sv @@
// ----------------------------------------------------------------------------
// odpack interfaces
// Valid/ready channels: source pixel, packed word, configuration write.
// ----------------------------------------------------------------------------
interface odpack_pix_if;
    logic                            valid;
    logic                            ready;
    logic [odpack_pkg::CHAN_W-1:0]   red;
    logic [odpack_pkg::CHAN_W-1:0]   green;
    logic [odpack_pkg::CHAN_W-1:0]   blue;
    logic [odpack_pkg::CHAN_W-1:0]   alpha;
    logic [odpack_pkg::POS_W-1:0]    pos_x;
    logic [odpack_pkg::POS_W-1:0]    pos_y;

    modport source (output valid, red, green, blue, alpha, pos_x, pos_y, input ready);
    modport sink   (input valid, red, green, blue, alpha, pos_x, pos_y, output ready);
endinterface

interface odpack_word_if;
    logic                            valid;
    logic                            ready;
    logic [odpack_pkg::WORD_W-1:0]   pixel_word;

    modport source (output valid, pixel_word, input ready);
    modport sink   (input valid, pixel_word, output ready);
endinterface

interface odpack_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [odpack_pkg::CFG_IDX_W-1:0]  index;
    logic [odpack_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/odpack_cfg.sv @@
// ----------------------------------------------------------------------------
// odpack_cfg
// Configuration registers: apply_dither and dither_mode.
// ----------------------------------------------------------------------------
module odpack_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [odpack_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [odpack_pkg::CFG_DAT_W-1:0]  i_data,
    output odpack_pkg::t_cfg                  o_cfg
);

    odpack_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.apply_dither <= 1'b0;
            r_cfg.dither_mode  <= odpack_pkg::MODE_NONE;
        end else if (i_wr) begin
            unique case (i_index)
                odpack_pkg::REG_APPLY_DITHER: r_cfg.apply_dither <= i_data[0];
                odpack_pkg::REG_DITHER_MODE:  r_cfg.dither_mode  <= i_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/odpack_dither.sv @@
// ----------------------------------------------------------------------------
// odpack_dither
// Threshold lookup, add with clamp to 0..255, and RGBA5551 packing.
// ----------------------------------------------------------------------------
module odpack_dither (
    input  odpack_pkg::t_cfg                i_cfg,
    input  logic [odpack_pkg::CHAN_W-1:0]   i_red,
    input  logic [odpack_pkg::CHAN_W-1:0]   i_green,
    input  logic [odpack_pkg::CHAN_W-1:0]   i_blue,
    input  logic [odpack_pkg::CHAN_W-1:0]   i_alpha,
    input  logic [1:0]                      i_xi,
    input  logic [1:0]                      i_yi,
    output logic [odpack_pkg::WORD_W-1:0]   o_word
);

    function automatic logic [odpack_pkg::CHAN_W-1:0] add_clamp(
        input logic [odpack_pkg::CHAN_W-1:0] chan,
        input odpack_pkg::t_thr              thr
    );
        logic signed [odpack_pkg::SUM_W-1:0] s;
        s = $signed({2'b00, chan}) + odpack_pkg::SUM_W'(thr);
        if (s < 0)
            return '0;
        else if (s > odpack_pkg::SUM_W'(odpack_pkg::CHAN_MAX))
            return odpack_pkg::CHAN_W'(odpack_pkg::CHAN_MAX);
        else
            return s[odpack_pkg::CHAN_W-1:0];
    endfunction

    odpack_pkg::t_thr                thr;
    logic                            dither_on;
    logic [odpack_pkg::CHAN_W-1:0]   red_c, green_c, blue_c;

    always_comb begin
        dither_on = i_cfg.apply_dither;
        thr       = '0;
        unique case (i_cfg.dither_mode)
            odpack_pkg::MODE_BAYER: thr = odpack_pkg::BAYER4[i_xi][i_yi];
            odpack_pkg::MODE_MAGIC: thr = odpack_pkg::MAGIC4[i_xi][i_yi];
            odpack_pkg::MODE_NONE,
            odpack_pkg::MODE_BLUE:  dither_on = 1'b0;
            default:                dither_on = 1'b0;
        endcase
        if (dither_on) begin
            red_c   = add_clamp(i_red, thr);
            green_c = add_clamp(i_green, thr);
            blue_c  = add_clamp(i_blue, thr);
        end else begin
            red_c   = i_red;
            green_c = i_green;
            blue_c  = i_blue;
        end
        o_word = {red_c[7:3], green_c[7:3], blue_c[7:3], (i_alpha != '0)};
    end

endmodule

@@ hdl/ordered_dither_rgba5551_pack.sv @@
// ----------------------------------------------------------------------------
// ordered_dither_rgba5551_pack
// Ordered-dither RGBA8888 to RGBA5551 packer, one pixel per clock when not stalled.
// ----------------------------------------------------------------------------
// Each pixel transaction on i_pix produces exactly one packed word on o_word,
// in order. Throughput is one pixel per cycle while o_word is not stalled; an
// accepted pixel goes through the input register, then the result register,
// with the table lookup, add/clamp and pack between them. The input register
// can still take a pixel while a finished word waits in the result register, so
// a stalled sink holds at most two pixels inside the block. i_cfg is always
// ready; write it only while no pixel is in flight.
// ----------------------------------------------------------------------------
module ordered_dither_rgba5551_pack (
    input  logic           i_clk,
    input  logic           i_rst_n,
    odpack_pix_if.sink     i_pix,
    odpack_word_if.source  o_word,
    odpack_cfg_if.sink     i_cfg
);

    // config
    odpack_pkg::t_cfg cfg;

    assign i_cfg.ready = 1'b1;

    odpack_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid & i_cfg.ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    // stage 1: input register
    logic                            r_s1_valid;
    logic [odpack_pkg::CHAN_W-1:0]   r_red, r_green, r_blue, r_alpha;
    logic [1:0]                      r_xi, r_yi;

    // stage 2: result register
    logic                            r_out_valid;
    logic [odpack_pkg::WORD_W-1:0]   r_word;
    logic [odpack_pkg::WORD_W-1:0]   n_word;

    logic s2_load;
    logic s1_load;

    // result register frees when empty or being taken
    assign s2_load     = r_s1_valid & (~r_out_valid | o_word.ready);
    assign i_pix.ready = ~r_s1_valid | s2_load;
    assign s1_load     = i_pix.valid & i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_red   <= i_pix.red;
            r_green <= i_pix.green;
            r_blue  <= i_pix.blue;
            r_alpha <= i_pix.alpha;
            r_xi    <= i_pix.pos_x[1:0];
            r_yi    <= i_pix.pos_y[1:0];
        end
    end

    odpack_dither u_dither (
        .i_cfg   (cfg),
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .i_alpha (r_alpha),
        .i_xi    (r_xi),
        .i_yi    (r_yi),
        .o_word  (n_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= 1'b1;
        end else if (o_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_word <= n_word;
        end
    end

    assign o_word.valid      = r_out_valid;
    assign o_word.pixel_word = r_word;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a pixel held in stage 1 behind a stalled result is not dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_word.ready) |=> r_s1_valid)
        else $error("stage 1 pixel lost while output stalled");

    // an accepted pixel always lands in stage 1
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_load |=> r_s1_valid)
        else $error("accepted pixel not registered");

    // alpha bit of the result follows the stage 1 alpha
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_load |=> (o_word.pixel_word[0] == ($past(r_alpha) != '0)))
        else $error("alpha bit mismatch");

endmodule

@@ bench/tb_ordered_dither_rgba5551_pack.sv @@
// ----------------------------------------------------------------------------
// tb_ordered_dither_rgba5551_pack
// Self-checking bench for the ordered-dither RGBA5551 packer. Directed pixels
// hit the clamp edges, alpha zero/nonzero and every mode code. Random pixels
// then run under a series of register settings with random idling on both
// sides, one long sink hold-off and a mid-phase sender drain. A scoreboard
// predicts every packed word and checks the words in order.
// ----------------------------------------------------------------------------
module tb_ordered_dither_rgba5551_pack;

    localparam int STALL_LIMIT = 1000;  // cycles with no transaction at all
    localparam int HOLD_CYCLES = 48;    // long sink hold-off, well past 2 slots
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 63;

    // Threshold tables, row = x & 3, column = y & 3
    localparam int BAYER_THR [4][4] = '{
        '{-4,  2, -3,  4},
        '{ 0, -2,  2, -1},
        '{-3,  3, -4,  3},
        '{ 1, -1,  1, -2}
    };
    localparam int MAGIC_THR [4][4] = '{
        '{-4,  2,  2, -1},
        '{ 3, -2, -3,  1},
        '{-3,  0,  4, -2},
        '{ 3, -1, -4,  1}
    };

    // Register settings for the random phases; both extremes of each
    // register and the unsupported mode code are visited.
    localparam logic       PH_APPLY [N_PHASES] = '{
        1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
    };
    localparam logic [1:0] PH_MODE  [N_PHASES] = '{
        odpack_pkg::MODE_BAYER, odpack_pkg::MODE_MAGIC, odpack_pkg::MODE_NONE,
        odpack_pkg::MODE_BLUE,  odpack_pkg::MODE_MAGIC, odpack_pkg::MODE_NONE,
        odpack_pkg::MODE_BAYER, odpack_pkg::MODE_MAGIC, odpack_pkg::MODE_BLUE,
        odpack_pkg::MODE_BAYER
    };

    typedef struct packed {
        logic [odpack_pkg::CHAN_W-1:0] red;
        logic [odpack_pkg::CHAN_W-1:0] green;
        logic [odpack_pkg::CHAN_W-1:0] blue;
        logic [odpack_pkg::CHAN_W-1:0] alpha;
        logic [odpack_pkg::POS_W-1:0]  pos_x;
        logic [odpack_pkg::POS_W-1:0]  pos_y;
    } t_px;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow registers, word predictor, in-order compare
    // ------------------------------------------------------------------------
    class dither_pack_scoreboard;
        logic                          apply_en;
        logic [1:0]                    mode;
        logic [odpack_pkg::WORD_W-1:0] pending_words [$];
        int                            n_pixels;
        int                            n_words;
        int                            n_errors;

        function new();
            apply_en = 1'b0;    // register reset values
            mode     = odpack_pkg::MODE_NONE;
            n_pixels = 0;
            n_words  = 0;
            n_errors = 0;
        endfunction

        function void set_reg(logic [odpack_pkg::CFG_IDX_W-1:0] idx,
                              logic [odpack_pkg::CFG_DAT_W-1:0] data);
            if (idx == odpack_pkg::REG_APPLY_DITHER)
                apply_en = data[0];
            else
                mode = data;
        endfunction

        function logic [odpack_pkg::WORD_W-1:0] pack_pixel(t_px p);
            int                            thr;
            logic [odpack_pkg::CHAN_W-1:0] chan [3];
            thr     = 0;
            chan[0] = p.red;
            chan[1] = p.green;
            chan[2] = p.blue;
            // blue-noise code and mode none both leave the channels alone
            if (apply_en && mode == odpack_pkg::MODE_BAYER)
                thr = BAYER_THR[p.pos_x[1:0]][p.pos_y[1:0]];
            else if (apply_en && mode == odpack_pkg::MODE_MAGIC)
                thr = MAGIC_THR[p.pos_x[1:0]][p.pos_y[1:0]];
            for (int i = 0; i < 3; i++) begin
                int s;
                s = int'(chan[i]) + thr;
                if (s < 0)
                    s = 0;
                if (s > odpack_pkg::CHAN_MAX)
                    s = odpack_pkg::CHAN_MAX;
                chan[i] = s[odpack_pkg::CHAN_W-1:0];
            end
            return {chan[0][7:3], chan[1][7:3], chan[2][7:3], p.alpha != '0};
        endfunction

        function void note_pixel(t_px p);
            n_pixels++;
            pending_words.push_back(pack_pixel(p));
        endfunction

        function void check_word(logic [odpack_pkg::WORD_W-1:0] got);
            logic [odpack_pkg::WORD_W-1:0] want;
            n_words++;
            if (pending_words.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: word %04h arrived with nothing expected", got);
                return;
            end
            want = pending_words.pop_front();
            if (got !== want) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: word %0d pixel_word expected %04h, got %04h",
                             n_words, want, got);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    odpack_pix_if  pix ();
    odpack_word_if word ();
    odpack_cfg_if  cfg ();

    ordered_dither_rgba5551_pack u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix),
        .o_word  (word),
        .i_cfg   (cfg)
    );

    dither_pack_scoreboard sb = new();

    bit pix_idle_en;    // sender draws random gaps
    bit sink_idle_en;   // receiver draws random gaps
    bit sink_hold_req;  // receiver does one long hold-off after its next transaction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitors: pixel and word transactions are seen at the same edge the DUT
    // sees them, reading pre-edge values.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && pix.valid && pix.ready)
            sb.note_pixel('{pix.red, pix.green, pix.blue, pix.alpha, pix.pos_x, pix.pos_y});
        if (rst_n && word.valid && word.ready)
            sb.check_word(word.pixel_word);
    end

    // Watchdog: ends the run if no transaction happens on any channel for too long
    initial begin
        int stall;
        stall = 0;
        do begin
            @(posedge clk);
            if ((pix.valid && pix.ready) || (word.valid && word.ready)
                    || (cfg.valid && cfg.ready) || !rst_n)
                stall = 0;
            else
                stall++;
        end while (stall < STALL_LIMIT);
        $display("ERROR: no transaction for %0d cycles, %0d words still pending",
                 STALL_LIMIT, sb.pending_words.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready gaps per word, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        word.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (sink_hold_req) begin
                word.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold_req = 1'b0;
            end
            gap = sink_idle_en ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                word.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            word.ready <= 1'b1;
            do @(posedge clk); while (!word.valid);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // One pixel transaction. valid stays high across back-to-back pixels so it
    // is never dropped and raised in the same step.
    task automatic send_pixel(input t_px p);
        int gap;
        gap = pix_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.red   <= p.red;
        pix.green <= p.green;
        pix.blue  <= p.blue;
        pix.alpha <= p.alpha;
        pix.pos_x <= p.pos_x;
        pix.pos_y <= p.pos_y;
        do @(posedge clk); while (!pix.ready);
    endtask

    // Stop offering pixels and wait for every predicted word. It never returns in
    // the step it was called in, so a following send never retouches valid in this step.
    task automatic drain_words();
        pix.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_words.size() != 0);
    endtask

    // Two back-to-back register writes; only called with the block idle.
    // apply_dither gets a random upper data bit, which the block must ignore.
    task automatic set_config(input logic apply, input logic [1:0] mode);
        cfg.valid <= 1'b1;
        cfg.index <= odpack_pkg::REG_APPLY_DITHER;
        cfg.data  <= {1'($urandom_range(0, 1)), apply};
        do @(posedge clk); while (!cfg.ready);
        sb.set_reg(cfg.index, cfg.data);
        cfg.index <= odpack_pkg::REG_DITHER_MODE;
        cfg.data  <= mode;
        do @(posedge clk); while (!cfg.ready);
        sb.set_reg(cfg.index, cfg.data);
        cfg.valid <= 1'b0;
    endtask

    function automatic t_px px(int r, int g, int b, int a, int x, int y);
        return '{r[7:0], g[7:0], b[7:0], a[7:0], x[11:0], y[11:0]};
    endfunction

    // Channels lean toward both ends so the clamps fire often
    function automatic logic [odpack_pkg::CHAN_W-1:0] rand_chan();
        unique case ($urandom_range(0, 3))
            0:       return odpack_pkg::CHAN_W'($urandom_range(0, 7));
            1:       return odpack_pkg::CHAN_W'($urandom_range(248, 255));
            default: return odpack_pkg::CHAN_W'($urandom);
        endcase
    endfunction

    function automatic t_px rand_pixel();
        t_px p;
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        p.alpha = ($urandom_range(0, 3) == 0) ? '0 : odpack_pkg::CHAN_W'($urandom);
        p.pos_x = odpack_pkg::POS_W'($urandom);
        p.pos_y = odpack_pkg::POS_W'($urandom);
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n         <= 1'b0;
        pix.valid     <= 1'b0;
        pix.red       <= '0;
        pix.green     <= '0;
        pix.blue      <= '0;
        pix.alpha     <= '0;
        pix.pos_x     <= '0;
        pix.pos_y     <= '0;
        cfg.valid     <= 1'b0;
        cfg.index     <= odpack_pkg::REG_APPLY_DITHER;
        cfg.data      <= '0;
        pix_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        sink_hold_req = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset settings, dithering off -----------------------
        send_pixel(px(0, 0, 0, 0, 0, 0));
        send_pixel(px(255, 255, 255, 255, 4095, 4095));
        send_pixel(px(8'h87, 8'h4C, 8'h33, 1, 12'hAAA, 12'h555));
        drain_words();

        // --- directed: Bayer, clamp at both ends --------------------------
        set_config(1'b1, odpack_pkg::MODE_BAYER);
        send_pixel(px(0, 1, 3, 8'h80, 0, 0));           // -4: clamps low
        send_pixel(px(255, 254, 252, 1, 0, 3));         // +4: clamps high
        send_pixel(px(3, 4, 7, 0, 2, 2));               // -4 near zero
        send_pixel(px(251, 252, 248, 255, 4095, 4094));
        send_pixel(px(7, 8, 247, 1, 1, 2));             // carries into next 5-bit step
        send_pixel(px(8'h10, 8'h11, 8'h12, 8'h40, 12'hFFC, 12'h003));
        drain_words();

        // --- directed: magic square --------------------------------------
        set_config(1'b1, odpack_pkg::MODE_MAGIC);
        send_pixel(px(0, 2, 4, 1, 0, 0));
        send_pixel(px(255, 252, 251, 0, 2, 2));
        send_pixel(px(2, 3, 1, 1, 3, 2));
        send_pixel(px(254, 253, 100, 1, 1, 0));
        drain_words();

        // --- directed: blue-noise code acts as no dither ------------------
        set_config(1'b1, odpack_pkg::MODE_BLUE);
        send_pixel(px(0, 255, 128, 1, 0, 0));
        send_pixel(px(255, 0, 7, 0, 0, 3));
        drain_words();

        // --- directed: matrix selected but dithering disabled -------------
        set_config(1'b0, odpack_pkg::MODE_BAYER);
        send_pixel(px(0, 255, 4, 1, 0, 0));
        send_pixel(px(255, 0, 252, 0, 0, 3));
        drain_words();

        // --- random phases -----------------------------------------------
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_config(PH_APPLY[ph], PH_MODE[ph]);
            // every fourth phase runs with no idling on either side
            pix_idle_en  = (ph % 4 != 2);
            sink_idle_en = (ph % 4 != 2);
            if (ph == 3) begin
                // sink stalls long while the sender streams: block fills up
                pix_idle_en   = 1'b0;
                sink_hold_req = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 6 && i == PHASE_ITEMS / 2)
                    drain_words();      // sender pause mid-phase
                send_pixel(rand_pixel());
            end
            drain_words();
        end

        // catch any stray word before the final check
        repeat (4) @(posedge clk);

        if (sb.pending_words.size() != 0) begin
            $display("ERROR: %0d expected words never arrived", sb.pending_words.size());
        end
        $display("Packed %0d pixels under %0d register settings (all modes, dither on/off),",
                 sb.n_pixels, N_PHASES + 5);
        $display("with random idling, a long sink stall and a sender drain; %0d errors.",
                 sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
